// File: hw/rtl/qou_pkg.sv
// Shared types, operation codes and helper functions of the quaternion orientation unit.
package qou_pkg;

	localparam int ACC_W = 67;

	localparam logic [2:0] OP_LOAD = 3'd0;
	localparam logic [2:0] OP_MUL  = 3'd1;
	localparam logic [2:0] OP_ROT  = 3'd2;
	localparam logic [2:0] OP_ADD  = 3'd3;
	localparam logic [2:0] OP_NORM = 3'd4;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MAC_GO,
		ST_MAC_WAIT,
		ST_ROOT_GO,
		ST_ROOT_WAIT,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [1:0] a_idx;
		logic [1:0] b_idx;
		logic       neg;
	} term_sel_t;

	typedef struct packed {
		logic [31:0] value;
		logic        sat;
	} clamp_t;

	// Operand indexes and sign of one term of the Hamilton product a*b.
	function automatic term_sel_t term_sel(input logic [1:0] comp, input logic [1:0] term);
		term_sel_t t;
		t = '0;
		unique case ({comp, term})
			4'h0: t = '{2'd0, 2'd0, 1'b0};
			4'h1: t = '{2'd1, 2'd1, 1'b1};
			4'h2: t = '{2'd2, 2'd2, 1'b1};
			4'h3: t = '{2'd3, 2'd3, 1'b1};
			4'h4: t = '{2'd0, 2'd1, 1'b0};
			4'h5: t = '{2'd1, 2'd0, 1'b0};
			4'h6: t = '{2'd2, 2'd3, 1'b0};
			4'h7: t = '{2'd3, 2'd2, 1'b1};
			4'h8: t = '{2'd0, 2'd2, 1'b0};
			4'h9: t = '{2'd2, 2'd0, 1'b0};
			4'hA: t = '{2'd3, 2'd1, 1'b0};
			4'hB: t = '{2'd1, 2'd3, 1'b1};
			4'hC: t = '{2'd0, 2'd3, 1'b0};
			4'hD: t = '{2'd3, 2'd0, 1'b0};
			4'hE: t = '{2'd1, 2'd2, 1'b0};
			4'hF: t = '{2'd2, 2'd1, 1'b1};
			default: t = '0;
		endcase
		return t;
	endfunction

	// Clamp a wide signed value to the 32-bit signed range.
	function automatic clamp_t clamp32(input logic signed [ACC_W-1:0] v);
		clamp_t c;
		if (v > 67'sd2147483647) begin
			c = '{32'h7FFF_FFFF, 1'b1};
		end else if (v < -67'sd2147483648) begin
			c = '{32'h8000_0000, 1'b1};
		end else begin
			c = '{v[31:0], 1'b0};
		end
		return c;
	endfunction

endpackage

// File: hw/rtl/qou_mac.sv
// Bit-serial signed multiply-accumulate unit, one multiplier bit per cycle.
module qou_mac (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic                              clear,
	input  logic                              neg,
	input  logic signed [31:0]                a,
	input  logic signed [31:0]                b,
	output logic signed [qou_pkg::ACC_W-1:0]  acc,
	output logic                              done
);

	logic signed [qou_pkg::ACC_W-1:0] acc_q;
	logic signed [qou_pkg::ACC_W-1:0] mcand_q;
	logic [31:0]                      mplier_q;
	logic [4:0]                       cnt_q;
	logic                             busy_q;
	logic                             done_q;
	logic                             neg_q;
	logic                             sub;

	// The top multiplier bit carries negative weight.
	assign sub = (cnt_q == 5'd31) ^ neg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			if (clear) begin
				acc_q <= '0;
			end
			mcand_q  <= qou_pkg::ACC_W'(a);
			mplier_q <= b;
			neg_q    <= neg;
		end else if (busy_q) begin
			if (mplier_q[0]) begin
				acc_q <= sub ? acc_q - mcand_q : acc_q + mcand_q;
			end
			mcand_q  <= mcand_q <<< 1;
			mplier_q <= mplier_q >> 1;
		end
	end

	assign acc  = acc_q;
	assign done = done_q;

endmodule

// File: hw/rtl/qou_sqrt.sv
// Digit-serial integer square root, two radicand bits per cycle.
module qou_sqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] radicand,
	output logic [31:0] root,
	output logic        done
);

	logic [63:0] rad_q;
	logic [32:0] rem_q;
	logic [31:0] root_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [34:0] r2;
	logic [34:0] trial;

	assign r2    = {rem_q, rad_q[63:62]};
	assign trial = {1'b0, root_q, 2'b01};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q <= rad_q << 2;
			if (r2 >= trial) begin
				rem_q  <= 33'(r2 - trial);
				root_q <= {root_q[30:0], 1'b1};
			end else begin
				rem_q  <= r2[32:0];
				root_q <= {root_q[30:0], 1'b0};
			end
		end
	end

	assign root = root_q;
	assign done = done_q;

endmodule

// File: hw/rtl/qou_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
module qou_div #(
	parameter int NW = 60
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [31:0]   den,
	output logic [NW-1:0] quo,
	output logic          done
);

	localparam int CW = $clog2(NW);
	localparam logic [CW-1:0] LAST = CW'(NW - 1);

	logic [NW-1:0] num_q;
	logic [NW-1:0] quo_q;
	logic [31:0]   rem_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [32:0]   r2;
	logic          ge;

	assign r2 = {rem_q, num_q[NW-1]};
	assign ge = r2 >= {1'b0, den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= num_q << 1;
			rem_q <= ge ? 32'(r2 - {1'b0, den}) : r2[31:0];
			quo_q <= {quo_q[NW-2:0], ge};
		end
	end

	assign quo  = quo_q;
	assign done = done_q;

endmodule

// File: hw/rtl/quaternion_orientation_unit_top.sv
// Top level of the quaternion orientation unit: sequencer, state and output register.
//
// Channel  Dir  Signals                       Content
// s_*      in   tvalid tready tdata tuser     operation and operand quaternion or vector
// m_*      out  tvalid tready tdata tuser     updated orientation and status flags
//
// One item is taken at a time. Load, unused codes and a zero normalize go straight to the
// done state. Multiply, rotate and add-scaled each run 16 serial multiplies on the
// bit-serial multiply-accumulate unit. Normalize runs 4 serial squares, a root and four
// divides. Reset sets the orientation to the identity and empties the output register.
// A waiting result does not block the input; a finished item waits only if the
// previous result has not been taken yet.
module quaternion_orientation_unit_top #(
	parameter int FRAC_BITS = 28
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [127:0] s_tdata,   // arg_r, arg_i, arg_j, arg_k (32 bits each, signed)
	input  logic [2:0]   s_tuser,   // operation
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [127:0] m_tdata,   // res_r, res_i, res_j, res_k (32 bits each, signed)
	output logic [1:0]   m_tuser    // zero_flag, saturated
);

	localparam int NW = 32 + FRAC_BITS;
	localparam logic signed [qou_pkg::ACC_W-1:0] HALF_MUL = 67'sd1 <<< (FRAC_BITS - 1);
	localparam logic signed [qou_pkg::ACC_W-1:0] HALF_ADD = 67'sd1 <<< FRAC_BITS;

	qou_pkg::state_t state_q, state_d;

	logic [2:0]         op_q;
	logic signed [31:0] arg_q    [4];
	logic signed [31:0] orient_q [4];
	logic signed [31:0] nw_q     [4];
	logic               sat_q;
	logic [1:0]         comp_q;
	logic [1:0]         term_q;
	logic [127:0]       out_data_q;
	logic [1:0]         out_user_q;
	logic               out_valid_q;

	logic               accept;
	logic               out_free;
	logic               st_zero;
	logic               in_zero;
	logic               mac_start, root_start, div_start;
	logic               mac_done, root_done, div_done;
	logic signed [qou_pkg::ACC_W-1:0] mac_acc;
	logic signed [31:0] argz [4];
	logic signed [31:0] mac_a, mac_b;
	logic               mac_neg;
	qou_pkg::term_sel_t sel;
	logic [63:0]        radicand;
	logic [31:0]        root;
	logic [31:0]        abs_c;
	logic [NW-1:0]      div_num;
	logic [NW-1:0]      quo;
	logic signed [qou_pkg::ACC_W-1:0] rnd_wide, rnd_shift, rnd_sum;
	qou_pkg::clamp_t    prod_c;
	qou_pkg::clamp_t    div_c;
	logic               is_add;

	assign accept   = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;
	assign is_add   = (op_q == qou_pkg::OP_ADD);
	assign st_zero  = (orient_q[0] == 0) && (orient_q[1] == 0) &&
	                  (orient_q[2] == 0) && (orient_q[3] == 0);
	assign in_zero  = (nw_q[0] == 0) && (nw_q[1] == 0) && (nw_q[2] == 0) && (nw_q[3] == 0);

	// Vector operations see a pure quaternion: the real part of the operand is zero.
	always_comb begin
		for (int n = 0; n < 4; n++) begin
			argz[n] = arg_q[n];
		end
		if (op_q == qou_pkg::OP_ROT || op_q == qou_pkg::OP_ADD) begin
			argz[0] = '0;
		end
	end

	// Operand selection for the current term; add-scaled puts the vector on the left.
	always_comb begin
		sel = qou_pkg::term_sel(comp_q, term_q);
		if (op_q == qou_pkg::OP_NORM) begin
			mac_a   = orient_q[term_q];
			mac_b   = orient_q[term_q];
			mac_neg = 1'b0;
		end else if (is_add) begin
			mac_a   = argz[sel.a_idx];
			mac_b   = orient_q[sel.b_idx];
			mac_neg = sel.neg;
		end else begin
			mac_a   = orient_q[sel.a_idx];
			mac_b   = argz[sel.b_idx];
			mac_neg = sel.neg;
		end
	end

	// Round half up after the exact four-term sum; add-scaled also halves and adds the old value.
	always_comb begin
		rnd_wide  = mac_acc + (is_add ? HALF_ADD : HALF_MUL);
		rnd_shift = is_add ? (rnd_wide >>> (FRAC_BITS + 1)) : (rnd_wide >>> FRAC_BITS);
		rnd_sum   = rnd_shift + (is_add ? qou_pkg::ACC_W'(orient_q[comp_q]) : '0);
		prod_c    = qou_pkg::clamp32(rnd_sum);
	end

	// The square sum only exceeds 64 bits when all components are the most negative value.
	assign radicand = (mac_acc[66:64] != 3'b000) ? '1 : mac_acc[63:0];

	assign abs_c   = orient_q[comp_q][31] ? 32'(-orient_q[comp_q]) : orient_q[comp_q];
	assign div_num = {abs_c, {FRAC_BITS{1'b0}}} + NW'(root >> 1);

	// Restore the sign of the quotient and clamp.
	always_comb begin
		if (!orient_q[comp_q][31]) begin
			if (quo[NW-1:31] != '0) begin
				div_c = '{32'h7FFF_FFFF, 1'b1};
			end else begin
				div_c = '{quo[31:0], 1'b0};
			end
		end else begin
			if ((quo[NW-1:32] != '0) || (quo[31] && (quo[30:0] != '0))) begin
				div_c = '{32'h8000_0000, 1'b1};
			end else begin
				div_c = '{32'(-quo[31:0]), 1'b0};
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			qou_pkg::ST_IDLE: begin
				if (accept) begin
					if (s_tuser == qou_pkg::OP_MUL || s_tuser == qou_pkg::OP_ROT ||
					    s_tuser == qou_pkg::OP_ADD) begin
						state_d = qou_pkg::ST_MAC_GO;
					end else if (s_tuser == qou_pkg::OP_NORM && !st_zero) begin
						state_d = qou_pkg::ST_MAC_GO;
					end else begin
						state_d = qou_pkg::ST_DONE;
					end
				end
			end
			qou_pkg::ST_MAC_GO:  state_d = qou_pkg::ST_MAC_WAIT;
			qou_pkg::ST_MAC_WAIT: begin
				if (mac_done) begin
					if (term_q != 2'd3) begin
						state_d = qou_pkg::ST_MAC_GO;
					end else if (op_q == qou_pkg::OP_NORM) begin
						state_d = qou_pkg::ST_ROOT_GO;
					end else if (comp_q == 2'd3) begin
						state_d = qou_pkg::ST_DONE;
					end else begin
						state_d = qou_pkg::ST_MAC_GO;
					end
				end
			end
			qou_pkg::ST_ROOT_GO: state_d = qou_pkg::ST_ROOT_WAIT;
			qou_pkg::ST_ROOT_WAIT: begin
				if (root_done) begin
					state_d = qou_pkg::ST_DIV_GO;
				end
			end
			qou_pkg::ST_DIV_GO:  state_d = qou_pkg::ST_DIV_WAIT;
			qou_pkg::ST_DIV_WAIT: begin
				if (div_done) begin
					state_d = (comp_q == 2'd3) ? qou_pkg::ST_DONE : qou_pkg::ST_DIV_GO;
				end
			end
			qou_pkg::ST_DONE: begin
				if (out_free) begin
					state_d = qou_pkg::ST_IDLE;
				end
			end
			default: state_d = qou_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready   = (state_q == qou_pkg::ST_IDLE);
		mac_start  = (state_q == qou_pkg::ST_MAC_GO);
		root_start = (state_q == qou_pkg::ST_ROOT_GO);
		div_start  = (state_q == qou_pkg::ST_DIV_GO);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= qou_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
			orient_q[0] <= 32'(64'sd1 <<< FRAC_BITS);
			orient_q[1] <= '0;
			orient_q[2] <= '0;
			orient_q[3] <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == qou_pkg::ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
				for (int n = 0; n < 4; n++) begin
					orient_q[n] <= nw_q[n];
				end
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Item and working registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= s_tuser;
			sat_q  <= 1'b0;
			comp_q <= '0;
			term_q <= '0;
			for (int n = 0; n < 4; n++) begin
				arg_q[n] <= s_tdata[32*n +: 32];
				nw_q[n]  <= (s_tuser == qou_pkg::OP_LOAD) ? s_tdata[32*n +: 32] : orient_q[n];
			end
		end
		if (state_q == qou_pkg::ST_MAC_WAIT && mac_done) begin
			term_q <= term_q + 2'd1;
			if (term_q == 2'd3 && op_q != qou_pkg::OP_NORM) begin
				nw_q[comp_q] <= prod_c.value;
				sat_q        <= sat_q | prod_c.sat;
				comp_q       <= comp_q + 2'd1;
			end
		end
		if (state_q == qou_pkg::ST_DIV_WAIT && div_done) begin
			nw_q[comp_q] <= div_c.value;
			sat_q        <= sat_q | div_c.sat;
			comp_q       <= comp_q + 2'd1;
		end
		if (state_q == qou_pkg::ST_DONE && out_free) begin
			out_data_q <= {nw_q[3], nw_q[2], nw_q[1], nw_q[0]};
			out_user_q <= {sat_q, in_zero};
		end
	end

	qou_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mac_start),
		.clear  (term_q == 2'd0),
		.neg    (mac_neg),
		.a      (mac_a),
		.b      (mac_b),
		.acc    (mac_acc),
		.done   (mac_done)
	);

	qou_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (root_start),
		.radicand (radicand),
		.root     (root),
		.done     (root_done)
	);

	qou_div #(.NW(NW)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (root),
		.quo    (quo),
		.done   (div_done)
	);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;

endmodule

// File: hw/rtl/qou_checker.sv
// Port-level checker of the quaternion orientation unit, bound to the top level.
module qou_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [127:0] m_tdata,
	input logic [1:0]   m_tuser
);

	// Only one item is in work at a time.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while an item is in work");

	// A result that waits keeps its value.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("pending result changed");

	// The zero flag agrees with the reported quaternion.
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser[0] == (m_tdata == '0)))
		else $error("zero flag does not match result");

	// A new result frees the input side in the same cycle.
	a_free: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> s_tready)
		else $error("input not ready after result");

endmodule

bind quaternion_orientation_unit_top qou_checker u_qou_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
